>>> rtl/calendar_epoch_converter_core_assert.svh
// assertion macros for the calendar epoch converter
`ifndef CALENDAR_EPOCH_CONVERTER_CORE_ASSERT_SVH
`define CALENDAR_EPOCH_CONVERTER_CORE_ASSERT_SVH
`ifndef SYNTH
`define CEC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("calendar epoch converter assertion failed");
`define CEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("calendar epoch converter assertion failed");
`else
`define CEC_ASSERT_IMP(lbl, ante, cons)
`define CEC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/cec_pkg.sv
// shared types, constants and month table of the calendar epoch converter
package cec_pkg;

  localparam int NumStages = 6;
  localparam int LastStage = NumStages - 1;

  localparam logic [10:0] CycleDays = 11'd1461;
  localparam logic [16:0] DaySecs   = 17'd86400;
  localparam logic [11:0] HourSecs  = 12'd3600;
  localparam logic [5:0]  MinSecs   = 6'd60;

  // floor(2^48 / 86400), quotient may come out one low
  localparam logic [31:0] DayRecip   = 32'd3257812230;
  localparam int          DayShift   = 48;
  // exact reciprocals for the bounded operands
  localparam logic [17:0] HourRecip  = 18'd149131;
  localparam int          HourShift  = 29;
  localparam logic [16:0] CycleRecip = 17'd91868;
  localparam int          CycleShift = 27;
  localparam logic [12:0] MinRecip   = 13'd4370;
  localparam int          MinShift   = 18;

  typedef logic [10:0] day_off_t;

  // day offset of each month start within a four-year cycle
  localparam day_off_t MonthStart [4][12] = '{
    '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
      11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
    '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
      11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
    '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
      11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
    '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
      11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
  };

  typedef enum logic {
    ReqToSeconds = 1'b0,
    ReqToDate    = 1'b1
  } req_e;

  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } pipe_ctl_t;

endpackage

>>> rtl/calendar_epoch_converter_core.sv
// top level of the calendar epoch converter
// converts a date and time (years after 2000) to seconds since 2000-01-01 00:00:00,
// or seconds since then back to a date and time, as chosen by the item's request kind
// input channel s_axis: tuser selects the request, 0 date to seconds, 1 seconds to date
// output channel m_axis: one result item for every input item, in order
// unused result fields of a request read as zero
// throughput: one item per cycle, set by the stage enables that let every stage
// load a new item in each cycle in which the output moves
// six register stages, each with a valid bit; a stage takes a new item when it is
// empty or its item moves on, so bubbles close up while the receiver stalls
// a stall holds the items from the output back to the nearest empty stage, and
// tready drops only once all stages are full
// reset clears the valid bits: no item is held, tvalid is low and tready is high
module calendar_epoch_converter_core import cec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // second[5:0] minute[11:6] hour[16:12] day[21:17] month[25:22] year[32:26]
  // seconds_total[64:33], zero fill[71:65]
  input  logic [71:0] s_axis_tdata_i,
  // req_type[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // seconds_total[31:0] second[37:32] minute[43:38] hour[48:44] day[53:49]
  // month[57:54] year[65:58], zero fill[71:66]
  output logic [71:0] m_axis_tdata_o
);

  pipe_ctl_t   ctl;
  req_e        req;
  logic [31:0] seconds_total;
  logic [5:0]  second, minute;
  logic [4:0]  hour, day;
  logic [3:0]  month;
  logic [7:0]  year;

  assign req = req_e'(s_axis_tuser_i);

  cec_pipe_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid_i),
    .out_ready_i (m_axis_tready_i),
    .ctl_o       (ctl)
  );

  cec_to_seconds u_to_seconds (
    .clk_i,
    .ctl_i           (ctl),
    .req_i           (req),
    .second_i        (s_axis_tdata_i[5:0]),
    .minute_i        (s_axis_tdata_i[11:6]),
    .hour_i          (s_axis_tdata_i[16:12]),
    .day_i           (s_axis_tdata_i[21:17]),
    .month_i         (s_axis_tdata_i[25:22]),
    .year_i          (s_axis_tdata_i[32:26]),
    .seconds_total_o (seconds_total)
  );

  cec_to_date u_to_date (
    .clk_i,
    .rst_ni,
    .ctl_i           (ctl),
    .req_i           (req),
    .seconds_total_i (s_axis_tdata_i[64:33]),
    .second_o        (second),
    .minute_o        (minute),
    .hour_o          (hour),
    .day_o           (day),
    .month_o         (month),
    .year_o          (year)
  );

  assign s_axis_tready_o = ctl.en[0];
  assign m_axis_tvalid_o = ctl.vld[LastStage];
  assign m_axis_tdata_o  = {6'd0, year, month, day, hour, minute, second, seconds_total};

endmodule

>>> rtl/cec_pipe_ctrl.sv
// valid bits and per-stage load enables of the converter pipeline
`include "calendar_epoch_converter_core_assert.svh"

module cec_pipe_ctrl import cec_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_ready_i,
  output pipe_ctl_t ctl_o
);

  logic [NumStages-1:0] vld_q, vld_d, en;

  always_comb begin
    en[LastStage] = ~vld_q[LastStage] | out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctl_o.en  = en;
  assign ctl_o.vld = vld_q;

  `CEC_ASSERT_IMP(a_en_chain, en[LastStage], &en)
  `CEC_ASSERT_IMP(a_stall_only_full, !en[0], &vld_q)
  `CEC_ASSERT_NEXT(a_first_stage_holds, vld_q[0] && !en[1], vld_q[0])

endmodule

>>> rtl/cec_to_seconds.sv
// date and time to seconds datapath
module cec_to_seconds import cec_pkg::*; (
  input  logic        clk_i,
  input  pipe_ctl_t   ctl_i,
  input  req_e        req_i,
  input  logic [5:0]  second_i,
  input  logic [5:0]  minute_i,
  input  logic [4:0]  hour_i,
  input  logic [4:0]  day_i,
  input  logic [3:0]  month_i,
  input  logic [6:0]  year_i,
  output logic [31:0] seconds_total_o
);

  logic [3:0]  mon_idx;
  logic [31:0] days_d, days_q;
  logic [16:0] hms_d, hms_q;
  logic [31:0] secs_d;
  logic [31:0] secs_q [NumStages-1];
  req_e        req_q [NumStages];

  always_comb begin
    priority if (month_i == 4'd0) begin
      mon_idx = 4'd0;
    end else if (month_i > 4'd12) begin
      mon_idx = 4'd11;
    end else begin
      mon_idx = month_i - 4'd1;
    end
    days_d = 32'(year_i[6:2]) * 32'(CycleDays)
           + 32'(MonthStart[year_i[1:0]][mon_idx]) + 32'(day_i) - 32'd1;
    hms_d  = 17'(17'(hour_i) * 17'(HourSecs) + 17'(minute_i) * 17'(MinSecs)
           + 17'(second_i));
    secs_d = days_q * 32'(DaySecs) + 32'(hms_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      days_q   <= days_d;
      hms_q    <= hms_d;
      req_q[0] <= req_i;
    end
    if (ctl_i.en[1]) begin
      secs_q[0] <= secs_d;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (ctl_i.en[k]) begin
        req_q[k] <= req_q[k-1];
      end
    end
    for (int k = 2; k < NumStages; k++) begin
      if (ctl_i.en[k]) begin
        secs_q[k-1] <= secs_q[k-2];
      end
    end
  end

  assign seconds_total_o = (req_q[LastStage] == ReqToSeconds) ? secs_q[LastStage-1] : '0;

endmodule

>>> rtl/cec_to_date.sv
// seconds to date and time datapath
`include "calendar_epoch_converter_core_assert.svh"

module cec_to_date import cec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pipe_ctl_t   ctl_i,
  input  req_e        req_i,
  input  logic [31:0] seconds_total_i,
  output logic [5:0]  second_o,
  output logic [5:0]  minute_o,
  output logic [4:0]  hour_o,
  output logic [4:0]  day_o,
  output logic [3:0]  month_o,
  output logic [7:0]  year_o
);

  req_e        req_q [NumStages];

  logic [63:0] day_prod;
  logic [15:0] q0_d;
  logic [31:0] s0_t_q;
  logic [15:0] s0_q0_q;

  logic [17:0] r0;
  logic [15:0] days_d;
  logic [16:0] rsec_d;
  logic [15:0] s1_days_q;
  logic [16:0] s1_rsec_q;

  logic [4:0]  hour_d;
  logic [5:0]  cyc_d;
  logic [15:0] s2_days_q;
  logic [16:0] s2_rsec_q;
  logic [4:0]  s2_hour_q;
  logic [5:0]  s2_cyc_q;

  logic [11:0] rem2_d;
  logic [10:0] dr_d;
  logic [4:0]  s3_hour_q;
  logic [5:0]  s3_cyc_q;
  logic [11:0] s3_rem2_q;
  logic [10:0] s3_dr_q;

  logic [5:0]  min_d;
  logic [1:0]  yc_d;
  logic [3:0]  mon_d;
  day_off_t    ms_d;
  logic [4:0]  s4_hour_q;
  logic [5:0]  s4_cyc_q;
  logic [11:0] s4_rem2_q;
  logic [10:0] s4_dr_q;
  logic [5:0]  s4_min_q;
  logic [1:0]  s4_yc_q;
  logic [3:0]  s4_mon_q;
  day_off_t    s4_ms_q;

  logic [5:0]  out_sec_q, out_min_q;
  logic [4:0]  out_hour_q, out_day_q;
  logic [3:0]  out_month_q;
  logic [7:0]  out_year_q;

  always_comb begin
    day_prod = 64'(seconds_total_i) * 64'(DayRecip);
    q0_d     = day_prod[63:48];

    // quotient estimate may be one low: one correction step
    r0 = 18'(s0_t_q - 32'(s0_q0_q) * 32'(DaySecs));
    if (r0 >= 18'(DaySecs)) begin
      days_d = s0_q0_q + 16'd1;
      rsec_d = 17'(r0 - 18'(DaySecs));
    end else begin
      days_d = s0_q0_q;
      rsec_d = 17'(r0);
    end

    hour_d = 5'((35'(s1_rsec_q) * 35'(HourRecip)) >> HourShift);
    cyc_d  = 6'((33'(s1_days_q) * 33'(CycleRecip)) >> CycleShift);

    rem2_d = 12'(s2_rsec_q - 17'(s2_hour_q) * 17'(HourSecs));
    dr_d   = 11'(s2_days_q - 16'(s2_cyc_q) * 16'(CycleDays));

    min_d = 6'((25'(s3_rem2_q) * 25'(MinRecip)) >> MinShift);
    yc_d  = 2'd0;
    for (int y = 1; y < 4; y++) begin
      if (s3_dr_q >= MonthStart[y][0]) begin
        yc_d = 2'(y);
      end
    end
    mon_d = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (s3_dr_q >= MonthStart[yc_d][m]) begin
        mon_d = 4'(m);
      end
    end
    ms_d = MonthStart[yc_d][mon_d];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      req_q[0] <= req_i;
      s0_t_q   <= seconds_total_i;
      s0_q0_q  <= q0_d;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (ctl_i.en[k]) begin
        req_q[k] <= req_q[k-1];
      end
    end
    if (ctl_i.en[1]) begin
      s1_days_q <= days_d;
      s1_rsec_q <= rsec_d;
    end
    if (ctl_i.en[2]) begin
      s2_days_q <= s1_days_q;
      s2_rsec_q <= s1_rsec_q;
      s2_hour_q <= hour_d;
      s2_cyc_q  <= cyc_d;
    end
    if (ctl_i.en[3]) begin
      s3_hour_q <= s2_hour_q;
      s3_cyc_q  <= s2_cyc_q;
      s3_rem2_q <= rem2_d;
      s3_dr_q   <= dr_d;
    end
    if (ctl_i.en[4]) begin
      s4_hour_q <= s3_hour_q;
      s4_cyc_q  <= s3_cyc_q;
      s4_rem2_q <= s3_rem2_q;
      s4_dr_q   <= s3_dr_q;
      s4_min_q  <= min_d;
      s4_yc_q   <= yc_d;
      s4_mon_q  <= mon_d;
      s4_ms_q   <= ms_d;
    end
    if (ctl_i.en[5]) begin
      out_sec_q   <= 6'(s4_rem2_q - 12'(s4_min_q) * 12'(MinSecs));
      out_min_q   <= s4_min_q;
      out_hour_q  <= s4_hour_q;
      out_day_q   <= 5'(s4_dr_q - s4_ms_q + 11'd1);
      out_month_q <= s4_mon_q + 4'd1;
      out_year_q  <= {s4_cyc_q, s4_yc_q};
    end
  end

  always_comb begin
    if (req_q[LastStage] == ReqToDate) begin
      second_o = out_sec_q;
      minute_o = out_min_q;
      hour_o   = out_hour_q;
      day_o    = out_day_q;
      month_o  = out_month_q;
      year_o   = out_year_q;
    end else begin
      second_o = '0;
      minute_o = '0;
      hour_o   = '0;
      day_o    = '0;
      month_o  = '0;
      year_o   = '0;
    end
  end

  `CEC_ASSERT_IMP(a_day_rem_range, ctl_i.vld[1], s1_rsec_q < 17'(DaySecs))
  `CEC_ASSERT_IMP(a_time_range, ctl_i.vld[LastStage] && req_q[LastStage] == ReqToDate,
    (second_o < 6'd60) && (minute_o < 6'd60) && (hour_o < 5'd24))
  `CEC_ASSERT_IMP(a_date_range, ctl_i.vld[LastStage] && req_q[LastStage] == ReqToDate,
    (day_o != 5'd0) && (month_o != 4'd0) && (month_o <= 4'd12) && (year_o <= 8'd136))

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// self-checking stream testbench for the calendar epoch converter with a built-in date model
module tb;
  import cec_pkg::*;

  localparam int unsigned DaysPerCycle = 1461;
  localparam int unsigned SecsPerMin   = 60;
  localparam int unsigned MinsPerHour  = 60;
  localparam int unsigned HoursPerDay  = 24;
  localparam int unsigned RandomItems  = 1700;
  localparam int unsigned CalmItems    = 300;
  localparam int unsigned CycleLimit   = 400000;

  typedef struct packed {
    req_e        req;
    logic [31:0] total;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } conv_req_t;

  typedef struct packed {
    logic [31:0] total;
    logic [7:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } conv_res_t;

  typedef struct {
    req_e        req;
    int unsigned sec, minute, hour, day, month, year;
    logic [31:0] total;
    bit          typed;
    logic [31:0] e_total;
    int unsigned e_sec, e_minute, e_hour, e_day, e_month, e_year;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [71:0] s_data = '0;
  logic        s_user = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [71:0] m_axis_tdata_o;

  conv_res_t   pending_conversions [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 20;

  calendar_epoch_converter_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  function automatic int unsigned month_len(int unsigned y4, int unsigned m0);
    case (m0)
      1: return (y4 == 0) ? 29 : 28;
      3, 5, 8, 10: return 30;
      default: return 31;
    endcase
  endfunction

  // day offset of a month start within the four-year cycle, year 0 leap
  function automatic int unsigned month_base(int unsigned y4, int unsigned m0);
    int unsigned d;
    int unsigned m;
    d = 365 * y4 + ((y4 != 0) ? 1 : 0);
    for (m = 0; m < m0; m++) d += month_len(y4, m);
    return d;
  endfunction

  function automatic logic [31:0] to_seconds(conv_req_t r);
    logic [63:0] days;
    logic [63:0] acc;
    int unsigned mon;
    mon = r.month;
    if (mon < 1) mon = 1;
    if (mon > 12) mon = 12;
    days = 64'(r.year / 4) * DaysPerCycle + 64'(month_base(r.year % 4, mon - 1))
         + 64'(r.day) - 64'd1;
    acc = ((days * HoursPerDay + 64'(r.hour)) * MinsPerHour + 64'(r.minute)) * SecsPerMin
        + 64'(r.second);
    return acc[31:0];
  endfunction

  function automatic conv_res_t to_date(logic [31:0] t);
    conv_res_t   r;
    int unsigned rest;
    int unsigned days;
    int unsigned y4;
    int unsigned m0;
    r = '0;
    r.second = 6'(t % SecsPerMin);
    rest = t / SecsPerMin;
    r.minute = 6'(rest % MinsPerHour);
    rest = rest / MinsPerHour;
    r.hour = 5'(rest % HoursPerDay);
    days = rest / HoursPerDay;
    r.year = 8'((days / DaysPerCycle) * 4);
    days = days % DaysPerCycle;
    y4 = 3;
    while (y4 > 0 && days < month_base(y4, 0)) y4--;
    m0 = 11;
    while (m0 > 0 && days < month_base(y4, m0)) m0--;
    r.day = 5'(days - month_base(y4, m0) + 1);
    r.month = 4'(m0 + 1);
    r.year = r.year + 8'(y4);
    return r;
  endfunction

  function automatic conv_res_t convert(conv_req_t r);
    conv_res_t res;
    res = '0;
    if (r.req == ReqToSeconds) res.total = to_seconds(r);
    else res = to_date(r.total);
    return res;
  endfunction

  function automatic conv_req_t random_request();
    conv_req_t   r;
    conv_req_t   anchor;
    int unsigned pick;
    r.req = req_e'($urandom_range(0, 1));
    r.second = 6'($urandom);
    r.minute = 6'($urandom);
    r.hour = 5'($urandom);
    r.day = 5'($urandom);
    r.month = 4'($urandom);
    r.year = 7'($urandom);
    r.total = $urandom;
    pick = $urandom_range(0, 9);
    if (r.req == ReqToSeconds) begin
      if (pick != 0) begin
        r.second = 6'($urandom_range(0, 59));
        r.minute = 6'($urandom_range(0, 59));
        r.hour = 5'($urandom_range(0, 23));
        r.year = 7'($urandom_range(0, 99));
        r.month = 4'($urandom_range(1, 12));
        r.day = 5'($urandom_range(1, month_len(r.year % 4, r.month - 1)));
      end
    end else if (pick < 4) begin
      r.total = $urandom_range(0, 32'd3155759999);
    end else if (pick < 8) begin
      // land near a month or year boundary
      anchor = '0;
      anchor.req = ReqToSeconds;
      anchor.year = 7'($urandom_range(0, 99));
      anchor.month = 4'($urandom_range(1, 12));
      anchor.day = 5'(1);
      r.total = to_seconds(anchor) + 32'($urandom_range(0, 4)) - 32'd2;
    end
    return r;
  endfunction

  function automatic string res_str(conv_res_t r);
    return $sformatf("total=%0d date=%0d-%0d-%0d time=%0d:%0d:%0d",
                     r.total, r.year, r.month, r.day, r.hour, r.minute, r.second);
  endfunction

  task automatic send_request(conv_req_t r, conv_res_t want);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {7'd0, r.total, r.year, r.month, r.day, r.hour, r.minute, r.second};
    s_user <= r.req;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_conversions.push_back(want);
  endtask

  // result side backpressure
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_pct != 0 && $urandom_range(1, 400) <= idle_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    conv_res_t got;
    conv_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got = '0;
      got.total = m_axis_tdata_o[31:0];
      got.second = m_axis_tdata_o[37:32];
      got.minute = m_axis_tdata_o[43:38];
      got.hour = m_axis_tdata_o[48:44];
      got.day = m_axis_tdata_o[53:49];
      got.month = m_axis_tdata_o[57:54];
      got.year = m_axis_tdata_o[65:58];
      if (pending_conversions.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, got %s", $time, res_str(got));
      end else begin
        want = pending_conversions.pop_front();
        if (got.total !== want.total || got.second !== want.second ||
            got.minute !== want.minute || got.hour !== want.hour ||
            got.day !== want.day || got.month !== want.month || got.year !== want.year) begin
          mismatches++;
          $display("%0t: mismatch, expected %s, got %s", $time, res_str(want), res_str(got));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d items outstanding", $time, pending_conversions.size());
      $display("calendar_epoch_converter_core regression: fail");
      $finish;
    end
  end

  initial begin
    dir_row_t    dir_rows [18];
    conv_req_t   rq;
    conv_res_t   want;
    int unsigned i;
    dir_rows = '{
      '{ReqToSeconds, 0, 0, 0, 1, 1, 0, 32'd0, 1, 32'd0, 0, 0, 0, 0, 0, 0},
      '{ReqToDate, 0, 0, 0, 0, 0, 0, 32'd0, 1, 32'd0, 0, 0, 0, 1, 1, 0},
      '{ReqToDate, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 32'd0, 15, 28, 6, 6, 2, 136},
      '{ReqToSeconds, 59, 59, 23, 31, 12, 99, 32'd0, 1, 32'd3155759999, 0, 0, 0, 0, 0, 0},
      '{ReqToDate, 0, 0, 0, 0, 0, 0, 32'd3155759999, 1, 32'd0, 59, 59, 23, 31, 12, 99},
      '{ReqToSeconds, 0, 0, 0, 0, 1, 0, 32'd0, 1, 32'd4294880896, 0, 0, 0, 0, 0, 0},
      '{ReqToSeconds, 0, 0, 0, 1, 0, 0, 32'd0, 1, 32'd0, 0, 0, 0, 0, 0, 0},
      '{ReqToSeconds, 0, 0, 0, 1, 15, 0, 32'd0, 1, 32'd28944000, 0, 0, 0, 0, 0, 0},
      '{ReqToSeconds, 63, 63, 31, 31, 15, 127, 32'hFFFF_FFFF, 0, 32'd0, 0, 0, 0, 0, 0, 0},
      '{ReqToSeconds, 0, 0, 0, 29, 2, 0, 32'd0, 1, 32'd5097600, 0, 0, 0, 0, 0, 0},
      '{ReqToDate, 0, 0, 0, 0, 0, 0, 32'd5097600, 1, 32'd0, 0, 0, 0, 29, 2, 0},
      '{ReqToDate, 0, 0, 0, 0, 0, 0, 32'd126230400, 1, 32'd0, 0, 0, 0, 1, 1, 4},
      '{ReqToDate, 0, 0, 0, 0, 0, 0, 32'd126230399, 1, 32'd0, 59, 59, 23, 31, 12, 3},
      '{ReqToSeconds, 0, 0, 0, 1, 1, 1, 32'd0, 1, 32'd31622400, 0, 0, 0, 0, 0, 0},
      '{ReqToDate, 0, 0, 0, 0, 0, 0, 32'd31622399, 1, 32'd0, 59, 59, 23, 31, 12, 0},
      '{ReqToDate, 63, 63, 31, 31, 15, 127, 32'hA5A5_A5A5, 0, 32'd0, 0, 0, 0, 0, 0, 0},
      '{ReqToSeconds, 1, 2, 3, 1, 3, 1, 32'h5A5A_5A5A, 0, 32'd0, 0, 0, 0, 0, 0, 0},
      '{ReqToDate, 0, 0, 0, 0, 0, 0, 32'd36719999, 1, 32'd0, 59, 59, 23, 28, 2, 1}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      rq.req = dir_rows[k].req;
      rq.second = 6'(dir_rows[k].sec);
      rq.minute = 6'(dir_rows[k].minute);
      rq.hour = 5'(dir_rows[k].hour);
      rq.day = 5'(dir_rows[k].day);
      rq.month = 4'(dir_rows[k].month);
      rq.year = 7'(dir_rows[k].year);
      rq.total = dir_rows[k].total;
      if (dir_rows[k].typed) begin
        want.total = dir_rows[k].e_total;
        want.second = 6'(dir_rows[k].e_sec);
        want.minute = 6'(dir_rows[k].e_minute);
        want.hour = 5'(dir_rows[k].e_hour);
        want.day = 5'(dir_rows[k].e_day);
        want.month = 4'(dir_rows[k].e_month);
        want.year = 8'(dir_rows[k].e_year);
      end else begin
        want = convert(rq);
      end
      send_request(rq, want);
    end

    for (i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0) begin
        if (i >= RandomItems - CalmItems) begin
          idle_pct = 0;
        end else begin
          case ($urandom_range(0, 3))
            0: idle_pct = 0;
            1: idle_pct = 10;
            2: idle_pct = 30;
            default: idle_pct = 60;
          endcase
        end
      end
      rq = random_request();
      send_request(rq, convert(rq));
    end
    s_valid <= 1'b0;

    while (pending_conversions.size() != 0) @(posedge clk_i);
    repeat (4 * NumStages) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("calendar_epoch_converter_core regression: pass");
    end else begin
      $display("calendar_epoch_converter_core regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/cec_pkg.sv
rtl/cec_pipe_ctrl.sv
rtl/cec_to_seconds.sv
rtl/cec_to_date.sv
rtl/calendar_epoch_converter_core.sv
dv/tb.sv
